FILE: rtl/sfv_pkg.sv
package sfv_pkg;

  localparam int KeyLimitDefault = 32;
  localparam int ValueLimit      = 64;
  localparam int RecordLimit     = 16;

  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] FrameMagic = 32'h5237_4452;

  localparam logic [3:0] MinFrame     = 4'd12;
  localparam logic [3:0] TrailerBytes = 4'd4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_KRES,
    PH_KLEN,
    PH_KEY,
    PH_VRES,
    PH_VLEN,
    PH_VAL,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ORD_EQUAL,
    ORD_GREATER,
    ORD_LESS
  } order_t;

  // Reflected CRC-32 advanced by one byte, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

endpackage

FILE: rtl/sfv_in_if.sv
interface sfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/sfv_out_if.sv
interface sfv_out_if;
  logic       valid;
  logic       ready;
  logic       frame_status;
  logic [7:0] record_count;
  logic       fenced_flag;

  modport source (output valid, output frame_status, output record_count,
                  output fenced_flag, input ready);
  modport sink (input valid, input frame_status, input record_count,
                input fenced_flag, output ready);
endinterface

FILE: rtl/sfv_ram.sv
module sfv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/snapshot_frame_validator.sv
// Channel   Dir  Payload                                    Item
// frame     in   data_byte[7:0], last_byte                  one frame byte
// verdict   out  frame_status, record_count[7:0], fenced    one per frame, on its last byte
//
// One frame byte is taken per cycle while frame.ready is high; the verdict register holds the result of
// a final byte and appears the cycle after it is taken.
// Each body byte's CRC step and key compare finish in the cycle it leaves the trailer window;
// the previous key sits in a RAM whose read address runs one byte ahead.
// Reset (rst, synchronous) clears all parser state; the key RAM is not cleared.
// frame.ready drops only while a verdict waits and verdict.ready is low.
module snapshot_frame_validator #(
  parameter int KEY_LIMIT = sfv_pkg::KeyLimitDefault
) (
  input logic      clk,
  input logic      rst,
  sfv_in_if.sink   frame,
  sfv_out_if.source verdict
);

  localparam int KeyAw = (KEY_LIMIT > 1) ? $clog2(KEY_LIMIT) : 1;

  logic [31:0]       window, window_next;
  logic [31:0]       crc, crc_next;
  sfv_pkg::phase_t   phase, phase_next;
  logic [7:0]        field_left, field_left_next;
  logic [15:0]       declared, declared_next;
  logic [7:0]        records_done, records_done_next;
  logic              fenced, fenced_next;
  logic [7:0]        prev_len, prev_len_next;
  logic [7:0]        cur_len, cur_len_next;
  logic [KeyAw-1:0]  key_pos, key_pos_next;
  sfv_pkg::order_t   key_order, key_order_next;
  logic              frame_error, frame_error_next;
  logic [3:0]        bytes_seen, bytes_seen_next;

  logic              out_valid;
  logic              out_status;
  logic [7:0]        out_count;
  logic              out_fenced;

  logic              in_acc;
  logic [7:0]        body;
  logic [7:0]        rec_inc;
  logic [7:0]        magic_byte;
  logic [7:0]        key_rd;
  logic              key_wr;
  logic [KeyAw-1:0]  key_rd_addr;
  logic              ok;

  assign in_acc       = frame.valid && frame.ready;
  assign frame.ready  = !out_valid || verdict.ready;
  assign body         = window[31:24];
  assign rec_inc      = records_done + 8'd1;

  assign verdict.valid        = out_valid;
  assign verdict.frame_status = out_status;
  assign verdict.record_count = out_count;
  assign verdict.fenced_flag  = out_fenced;

  // The read address follows the next key position, so the RAM output lines
  // up with the key byte that is parsed in the following accepted cycle.
  assign key_rd_addr = in_acc ? key_pos_next : key_pos;

  sfv_ram #(
    .WIDTH (8),
    .DEPTH (KEY_LIMIT)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (key_pos),
    .wr_data (body),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd)
  );

  always_comb begin
    unique case (field_left[1:0])
      2'd0:    magic_byte = sfv_pkg::FrameMagic[31:24];
      2'd1:    magic_byte = sfv_pkg::FrameMagic[23:16];
      2'd2:    magic_byte = sfv_pkg::FrameMagic[15:8];
      default: magic_byte = sfv_pkg::FrameMagic[7:0];
    endcase
  end

  always_comb begin
    window_next       = window;
    crc_next          = crc;
    phase_next        = phase;
    field_left_next   = field_left;
    declared_next     = declared;
    records_done_next = records_done;
    fenced_next       = fenced;
    prev_len_next     = prev_len;
    cur_len_next      = cur_len;
    key_pos_next      = key_pos;
    key_order_next    = key_order;
    frame_error_next  = frame_error;
    bytes_seen_next   = bytes_seen;
    key_wr            = 1'b0;
    ok                = 1'b0;

    if (in_acc) begin
      window_next = {window[23:0], frame.data_byte};
      if (bytes_seen != sfv_pkg::MinFrame) begin
        bytes_seen_next = bytes_seen + 4'd1;
      end

      // The oldest byte of the window leaves it as a body byte.
      if (bytes_seen >= sfv_pkg::TrailerBytes) begin
        crc_next = sfv_pkg::crc_byte(crc, body);
        if (!frame_error) begin
          unique case (phase)
            sfv_pkg::PH_HEADER: begin
              if (field_left < 8'd4) begin
                if (body != magic_byte) frame_error_next = 1'b1;
              end else if (field_left == 8'd4) begin
                declared_next = {body, 8'h00};
              end else if (field_left == 8'd5) begin
                declared_next = {declared[15:8], body};
                if ({declared[15:8], body} > 16'(sfv_pkg::RecordLimit)) begin
                  frame_error_next = 1'b1;
                end
              end else if (field_left == 8'd6) begin
                if (body > 8'd1) frame_error_next = 1'b1;
                fenced_next = body[0];
              end else begin
                if (body != 8'd1) frame_error_next = 1'b1;
                phase_next = (declared == 16'd0) ? sfv_pkg::PH_DONE : sfv_pkg::PH_KRES;
              end
              field_left_next = field_left + 8'd1;
            end
            sfv_pkg::PH_KRES, sfv_pkg::PH_VRES: begin
              if (body != 8'd0) frame_error_next = 1'b1;
              phase_next = (phase == sfv_pkg::PH_KRES) ? sfv_pkg::PH_KLEN
                                                       : sfv_pkg::PH_VLEN;
            end
            sfv_pkg::PH_KLEN: begin
              if (body == 8'd0 || body > 8'(KEY_LIMIT)) begin
                frame_error_next = 1'b1;
              end else begin
                cur_len_next    = body;
                field_left_next = body;
                key_pos_next    = '0;
                key_order_next  = sfv_pkg::ORD_EQUAL;
                phase_next      = sfv_pkg::PH_KEY;
              end
            end
            sfv_pkg::PH_KEY: begin
              if (8'(key_pos) >= 8'(KEY_LIMIT) || field_left == 8'd0) begin
                frame_error_next = 1'b1;
              end else begin
                if (records_done != 8'd0 && key_order == sfv_pkg::ORD_EQUAL) begin
                  if (8'(key_pos) >= prev_len || body > key_rd) begin
                    key_order_next = sfv_pkg::ORD_GREATER;
                  end else if (body < key_rd) begin
                    key_order_next = sfv_pkg::ORD_LESS;
                  end
                end
                key_wr          = 1'b1;
                key_pos_next    = key_pos + KeyAw'(1);
                field_left_next = field_left - 8'd1;
                if (field_left == 8'd1) begin
                  if (records_done != 8'd0 && key_order_next != sfv_pkg::ORD_GREATER) begin
                    frame_error_next = 1'b1;
                  end
                  prev_len_next = cur_len;
                  phase_next    = sfv_pkg::PH_VRES;
                end
              end
            end
            sfv_pkg::PH_VLEN: begin
              if (body > 8'(sfv_pkg::ValueLimit)) begin
                frame_error_next = 1'b1;
              end else if (body == 8'd0) begin
                records_done_next = rec_inc;
                phase_next = (16'(rec_inc) == declared) ? sfv_pkg::PH_DONE
                                                        : sfv_pkg::PH_KRES;
              end else begin
                field_left_next = body;
                phase_next      = sfv_pkg::PH_VAL;
              end
            end
            sfv_pkg::PH_VAL: begin
              field_left_next = field_left - 8'd1;
              if (field_left == 8'd1) begin
                records_done_next = rec_inc;
                phase_next = (16'(rec_inc) == declared) ? sfv_pkg::PH_DONE
                                                        : sfv_pkg::PH_KRES;
              end
            end
            default: begin
              // Any body byte after the last record is a trailing byte.
              frame_error_next = 1'b1;
            end
          endcase
        end
      end

      ok = !frame_error_next && bytes_seen_next == sfv_pkg::MinFrame
           && phase_next == sfv_pkg::PH_DONE && ~crc_next == window_next;

      if (frame.last_byte) begin
        window_next       = 32'h0;
        crc_next          = sfv_pkg::CrcInit;
        phase_next        = sfv_pkg::PH_HEADER;
        field_left_next   = 8'd0;
        declared_next     = 16'd0;
        records_done_next = 8'd0;
        fenced_next       = 1'b0;
        prev_len_next     = 8'd0;
        cur_len_next      = 8'd0;
        key_order_next    = sfv_pkg::ORD_EQUAL;
        frame_error_next  = 1'b0;
        bytes_seen_next   = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= 32'h0;
      crc          <= sfv_pkg::CrcInit;
      phase        <= sfv_pkg::PH_HEADER;
      field_left   <= 8'd0;
      declared     <= 16'd0;
      records_done <= 8'd0;
      fenced       <= 1'b0;
      prev_len     <= 8'd0;
      cur_len      <= 8'd0;
      key_pos      <= '0;
      key_order    <= sfv_pkg::ORD_EQUAL;
      frame_error  <= 1'b0;
      bytes_seen   <= 4'd0;
      out_valid    <= 1'b0;
    end else begin
      window       <= window_next;
      crc          <= crc_next;
      phase        <= phase_next;
      field_left   <= field_left_next;
      declared     <= declared_next;
      records_done <= records_done_next;
      fenced       <= fenced_next;
      prev_len     <= prev_len_next;
      cur_len      <= cur_len_next;
      key_pos      <= key_pos_next;
      key_order    <= key_order_next;
      frame_error  <= frame_error_next;
      bytes_seen   <= bytes_seen_next;
      if (in_acc && frame.last_byte) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A valid verdict needs the parser in its done phase, so the header fields
  // cannot change on the final byte and the registered values are the ones to report.
  always_ff @(posedge clk) begin
    if (in_acc && frame.last_byte) begin
      out_status <= !ok;
      out_count  <= ok ? declared[7:0] : 8'd0;
      out_fenced <= ok ? fenced : 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_verdict_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_acc && frame.last_byte |=> out_valid)
    else $error("no verdict after the final byte of a frame");

  a_corrupt_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_count == 8'd0 && !out_fenced)
    else $error("corrupt verdict carries header fields");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && frame.last_byte |=> bytes_seen == 4'd0 && phase == sfv_pkg::PH_HEADER
      && !frame_error)
    else $error("parser state not cleared after a frame");

  a_key_bytes_left: assert property (@(posedge clk) disable iff (rst)
    phase == sfv_pkg::PH_KEY |-> field_left != 8'd0 && field_left <= 8'(KEY_LIMIT))
    else $error("key byte count out of range");

  a_bytes_seen_sat: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= sfv_pkg::MinFrame)
    else $error("byte counter passed its saturation point");
`endif

endmodule

FILE: sim/snapshot_frame_validator_chk.sv
`timescale 1ns / 1ps

package sfv_tb_pkg;

  // Reflected CRC-32, one data bit at a time starting from bit 0.
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ sfv_pkg::CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

module snapshot_frame_validator_chk (
  input  logic clk,
  input  logic rst,
  sfv_in_if    frame,
  sfv_out_if   verdict,
  output int   mismatches,
  output int   pending,
  output int   good_frames,
  output int   bad_frames
);
  import sfv_pkg::*;
  import sfv_tb_pkg::*;

  localparam int KeyMax = KeyLimitDefault;

  typedef struct packed {
    logic       status;
    logic [7:0] count;
    logic       fenced;
  } verdict_t;

  logic [31:0] window;
  logic [31:0] crc;
  phase_t      phase;
  logic [7:0]  field_left;
  logic [15:0] declared;
  logic [7:0]  recs_done;
  logic        fenced_hdr;
  logic [7:0]  last_key [KeyMax];
  logic [7:0]  last_key_len;
  logic [7:0]  key_len;
  order_t      order;
  logic        broken;
  int          seen;
  verdict_t    verdict_q[$];

  task automatic clear_frame();
    window       = '0;
    crc          = CrcInit;
    phase        = PH_HEADER;
    field_left   = '0;
    declared     = '0;
    recs_done    = '0;
    fenced_hdr   = 1'b0;
    last_key_len = '0;
    key_len      = '0;
    order        = ORD_EQUAL;
    broken       = 1'b0;
    seen         = 0;
  endtask

  task automatic close_record();
    recs_done = recs_done + 8'd1;
    phase = (16'(recs_done) == declared) ? PH_DONE : PH_KRES;
  endtask

  // A byte leaving the trailer window belongs to the body.
  task automatic parse_byte(input logic [7:0] b);
    int pos;
    crc = crc32_step(crc, b);
    if (broken) return;
    case (phase)
      PH_HEADER: begin
        if (field_left < 4) begin
          if (b != 8'(FrameMagic >> (8 * (3 - int'(field_left))))) broken = 1'b1;
        end else if (field_left == 4) begin
          declared = {b, 8'h00};
        end else if (field_left == 5) begin
          declared = declared | 16'(b);
          if (declared > RecordLimit) broken = 1'b1;
        end else if (field_left == 6) begin
          if (b > 1) broken = 1'b1;
          fenced_hdr = b[0];
        end else begin
          if (b != 8'd1) broken = 1'b1;
          phase = (declared == 0) ? PH_DONE : PH_KRES;
        end
        field_left = field_left + 8'd1;
      end
      PH_KRES, PH_VRES: begin
        if (b != 0) broken = 1'b1;
        phase = (phase == PH_KRES) ? PH_KLEN : PH_VLEN;
      end
      PH_KLEN: begin
        if (b == 0 || b > KeyMax) begin
          broken = 1'b1;
        end else begin
          key_len    = b;
          field_left = b;
          order      = ORD_EQUAL;
          phase      = PH_KEY;
        end
      end
      PH_KEY: begin
        pos = int'(key_len) - int'(field_left);
        if (pos >= KeyMax || field_left == 0) begin
          broken = 1'b1;
        end else begin
          // Only the first differing byte decides the order; a longer key wins a tie.
          if (recs_done > 0 && order == ORD_EQUAL) begin
            if (pos >= last_key_len || b > last_key[pos]) order = ORD_GREATER;
            else if (b < last_key[pos]) order = ORD_LESS;
          end
          last_key[pos] = b;
          field_left = field_left - 8'd1;
          if (field_left == 0) begin
            if (recs_done > 0 && order != ORD_GREATER) broken = 1'b1;
            last_key_len = key_len;
            phase = PH_VRES;
          end
        end
      end
      PH_VLEN: begin
        if (b > ValueLimit) begin
          broken = 1'b1;
        end else if (b == 0) begin
          close_record();
        end else begin
          field_left = b;
          phase = PH_VAL;
        end
      end
      PH_VAL: begin
        field_left = field_left - 8'd1;
        if (field_left == 0) close_record();
      end
      default: broken = 1'b1;
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic     ok;
    verdict_t v;
    if (seen >= TrailerBytes) parse_byte(window[31:24]);
    window = {window[23:0], b};
    if (seen < MinFrame) seen++;
    if (last) begin
      ok = !broken && seen >= MinFrame && phase == PH_DONE && ~crc == window;
      v.status = !ok;
      v.count  = ok ? declared[7:0] : 8'd0;
      v.fenced = ok ? fenced_hdr : 1'b0;
      verdict_q.push_back(v);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH frame %0d %s: got %0d, expected %0d",
             good_frames + bad_frames, what, got, want);
    mismatches++;
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch("verdict with nothing outstanding, status", verdict.frame_status, -1);
      return;
    end
    want = verdict_q.pop_front();
    if (verdict.frame_status !== want.status)
      report_mismatch("frame_status", verdict.frame_status, want.status);
    if (verdict.record_count !== want.count)
      report_mismatch("record_count", verdict.record_count, want.count);
    if (verdict.fenced_flag !== want.fenced)
      report_mismatch("fenced_flag", verdict.fenced_flag, want.fenced);
    if (want.status) bad_frames++;
    else good_frames++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      verdict_q.delete();
      mismatches  = 0;
      good_frames = 0;
      bad_frames  = 0;
    end else begin
      // A verdict never leaves in the cycle its final byte is taken, so check it first.
      if (verdict.valid && verdict.ready) check_verdict();
      if (frame.valid && frame.ready) take_byte(frame.data_byte, frame.last_byte);
    end
    pending = verdict_q.size();
  end

endmodule

FILE: sim/snapshot_frame_validator_tb.sv
`timescale 1ns / 1ps

module snapshot_frame_validator_tb;
  import sfv_pkg::*;
  import sfv_tb_pkg::*;

  typedef enum int {
    DEF_NONE,
    DEF_MAGIC,
    DEF_COUNT_HIGH,
    DEF_FENCED,
    DEF_SCHEMA,
    DEF_KRES,
    DEF_KLEN_ZERO,
    DEF_KLEN_BIG,
    DEF_VRES,
    DEF_VLEN_BIG,
    DEF_KEY_ORDER,
    DEF_TRUNCATE,
    DEF_TRAILING,
    DEF_CRC,
    DEF_SHORT,
    DEF_NOISE
  } defect_t;

  localparam int CycleLimit = 100000;
  localparam int HoldCycles = 60;
  localparam int ByteTarget = 850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic stall_sink = 1'b0;
  bit   idle_on = 1'b1;

  int mismatches;
  int pending;
  int good_frames;
  int bad_frames;
  int bytes_sent;
  int frames_sent;
  int cycle_count;

  logic [7:0] frame_bytes[$];
  logic [7:0] key_cur[$];
  logic [7:0] key_prev[$];

  sfv_in_if  frame();
  sfv_out_if verdict();

  always #10 clk = ~clk;

  snapshot_frame_validator dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .verdict (verdict)
  );

  snapshot_frame_validator_chk verdict_chk (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .verdict     (verdict),
    .mismatches  (mismatches),
    .pending     (pending),
    .good_frames (good_frames),
    .bad_frames  (bad_frames)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d verdicts outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Verdict receiver: short random stalls, plus one long hold when asked for.
  initial begin : verdict_sink
    int burst;
    burst = 0;
    verdict.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_sink) begin
        verdict.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        stall_sink <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        verdict.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(0, 4);
        verdict.ready <= 1'b0;
      end else begin
        verdict.ready <= 1'b1;
      end
    end
  end

  // Builds the key of the next record from the previous one, either strictly
  // greater or not (equal, a shorter prefix, or smaller at some byte).
  task automatic next_key(input bit greater);
    int p;
    int n;
    key_cur.delete();
    if (greater) begin
      p = $urandom_range(0, key_prev.size());
      if (p < key_prev.size() && key_prev[p] != 8'hFF) begin
        for (int i = 0; i <= p; i++) key_cur.push_back(key_prev[i]);
        key_cur[p] = 8'($urandom_range(key_prev[p] + 1, 255));
      end else begin
        key_cur = key_prev;
        if (key_cur.size() < KeyLimitDefault) key_cur.push_back(8'($urandom));
      end
      n = $urandom_range(0, 2);
      while (n > 0 && key_cur.size() < KeyLimitDefault) begin
        key_cur.push_back(8'($urandom));
        n--;
      end
    end else begin
      p = $urandom_range(0, key_prev.size() - 1);
      case ($urandom_range(0, 2))
        0: key_cur = key_prev;
        1: begin
          n = $urandom_range(1, key_prev.size());
          for (int i = 0; i < n; i++) key_cur.push_back(key_prev[i]);
        end
        default: begin
          for (int i = 0; i <= p; i++) key_cur.push_back(key_prev[i]);
          if (key_prev[p] != 0) begin
            key_cur[p] = 8'($urandom_range(0, key_prev[p] - 1));
            n = $urandom_range(0, 2);
            while (n > 0 && key_cur.size() < KeyLimitDefault) begin
              key_cur.push_back(8'($urandom));
              n--;
            end
          end
        end
      endcase
    end
  endtask

  task automatic build_frame(input defect_t d, input bit long_mode, input int max_recs);
    logic [7:0]  body[$];
    logic [31:0] crc;
    logic [15:0] count;
    int          nrec;
    int          bad_rec;
    int          klen;
    int          vlen;
    int          target;
    bit          hit;
    nrec = long_mode ? $urandom_range(1, 2) : $urandom_range(0, max_recs);
    if (!long_mode && max_recs > 0 && $urandom_range(0, 19) == 0) nrec = RecordLimit;
    if (nrec == 0 && d >= DEF_KRES && d <= DEF_TRUNCATE) nrec = 1;
    if (d == DEF_KEY_ORDER && nrec < 2) nrec = 2;
    if (d == DEF_KEY_ORDER) bad_rec = $urandom_range(1, nrec - 1);
    else bad_rec = $urandom_range(0, (nrec > 0) ? nrec - 1 : 0);
    count = 16'(nrec);
    if (d == DEF_COUNT_HIGH)
      count = $urandom_range(0, 1) ? 16'($urandom_range(RecordLimit + 1, 255))
                                   : 16'($urandom_range(256, 65535));

    for (int i = 3; i >= 0; i--) body.push_back(FrameMagic[8*i +: 8]);
    if (d == DEF_MAGIC) body[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    body.push_back(count[15:8]);
    body.push_back(count[7:0]);
    body.push_back((d == DEF_FENCED) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(0, 1)));
    body.push_back((d == DEF_SCHEMA) ? 8'($urandom_range(2, 256)) : 8'd1);

    for (int r = 0; r < nrec; r++) begin
      hit = (r == bad_rec);
      if (r == 0) begin
        if (long_mode)
          klen = $urandom_range(0, 1) ? KeyLimitDefault : $urandom_range(1, KeyLimitDefault);
        else
          klen = $urandom_range(1, 4);
        key_cur.delete();
        repeat (klen) key_cur.push_back(8'($urandom));
      end else begin
        next_key(!(d == DEF_KEY_ORDER && hit));
      end
      body.push_back((d == DEF_KRES && hit) ? 8'($urandom_range(1, 255)) : 8'd0);
      if (d == DEF_KLEN_ZERO && hit) body.push_back(8'd0);
      else if (d == DEF_KLEN_BIG && hit)
        body.push_back(8'($urandom_range(KeyLimitDefault + 1, 255)));
      else body.push_back(8'(key_cur.size()));
      foreach (key_cur[i]) body.push_back(key_cur[i]);
      body.push_back((d == DEF_VRES && hit) ? 8'($urandom_range(1, 255)) : 8'd0);
      if (long_mode)
        vlen = $urandom_range(0, 1) ? ValueLimit : $urandom_range(0, ValueLimit);
      else
        vlen = $urandom_range(0, 4);
      if (d == DEF_VLEN_BIG && hit) begin
        body.push_back(8'($urandom_range(ValueLimit + 1, 255)));
        vlen = $urandom_range(0, 3);
      end else begin
        body.push_back(8'(vlen));
      end
      repeat (vlen) body.push_back(8'($urandom));
      key_prev = key_cur;
    end

    if (d == DEF_TRUNCATE) repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
    if (d == DEF_TRAILING) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));

    crc = CrcInit;
    foreach (body[i]) crc = crc32_step(crc, body[i]);
    crc = ~crc;
    if (d == DEF_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
    frame_bytes = body;
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(crc[8*i +: 8]);

    if (d == DEF_SHORT) begin
      target = $urandom_range(1, MinFrame - 1);
      while (frame_bytes.size() > target) void'(frame_bytes.pop_back());
    end
    if (d == DEF_NOISE) begin
      frame_bytes.delete();
      repeat ($urandom_range(12, 24)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        frame.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      frame.valid     <= 1'b1;
      frame.data_byte <= frame_bytes[i];
      frame.last_byte <= (i == frame_bytes.size() - 1);
      do @(posedge clk); while (!frame.ready);
      bytes_sent++;
    end
    frames_sent++;
  endtask

  task automatic random_frame();
    defect_t d;
    bit      long_mode;
    d = ($urandom_range(0, 99) < 50) ? DEF_NONE : defect_t'($urandom_range(1, DEF_NOISE));
    long_mode = ($urandom_range(0, 9) == 0);
    build_frame(d, long_mode, 3);
    send_frame();
  endtask

  // Stops offering bytes until every verdict has been taken.
  task automatic wait_drained();
    frame.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    frame.valid     <= 1'b0;
    frame.data_byte <= 8'h00;
    frame.last_byte <= 1'b0;
    bytes_sent  = 0;
    frames_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-byte frame, the smallest valid frame, and that frame one byte short.
    frame_bytes = '{8'hFF};
    send_frame();
    build_frame(DEF_NONE, 1'b0, 0);
    send_frame();
    void'(frame_bytes.pop_back());
    send_frame();

    while (bytes_sent < ByteTarget / 2) random_frame();

    // Hold the verdict side while short frames keep arriving so the input stalls.
    stall_sink <= 1'b1;
    repeat (8) begin
      build_frame(DEF_SHORT, 1'b0, 0);
      send_frame();
    end
    wait_drained();

    while (bytes_sent < ByteTarget * 3 / 4) random_frame();
    idle_on <= 1'b0;
    while (bytes_sent < ByteTarget) random_frame();

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d bytes in %0d frames; %0d verdicts valid, %0d corrupt.",
             bytes_sent, frames_sent, good_frames, bad_frames);
    $display("Frames mixed clean records with header, record, key order, CRC, short, %s",
             "truncated and trailing-byte faults under random stalls.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sfv_pkg.sv
rtl/sfv_in_if.sv
rtl/sfv_out_if.sv
rtl/sfv_ram.sv
rtl/snapshot_frame_validator.sv
sim/snapshot_frame_validator_chk.sv
sim/snapshot_frame_validator_tb.sv
